### rtl/rgd_pkg.sv
// shared constants, widths and helpers for the random gate distributor
`default_nettype none
package rgd_pkg;

  localparam int NUM_GATES  = 8;
  localparam int PULSE_BITS = 16;

  localparam int GATE_BITS = $clog2(NUM_GATES);
  localparam int SPAN_W    = GATE_BITS + 1;
  localparam int REQ_W     = 6;
  localparam int RND_W     = 32;
  localparam int CNT_W     = $clog2(RND_W);
  localparam int MODE_W    = 2;

  localparam int IN_W       = 2 + 2 * REQ_W + RND_W;
  localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = NUM_GATES + MODE_W;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [PULSE_BITS-1:0] PULSE_RESET = PULSE_BITS'(48);

  localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GATE    = 2'd2;

  // clamp a signed request to 0..NUM_GATES-1
  function automatic logic [GATE_BITS-1:0] clamp_gate(input logic [REQ_W-1:0] v);
    if (v[REQ_W-1]) begin
      return '0;
    end else if (v > REQ_W'(NUM_GATES - 1)) begin
      return GATE_BITS'(NUM_GATES - 1);
    end else begin
      return v[GATE_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/rgd_mod.sv
// bit-serial remainder unit: one dividend bit per cycle against a small divisor
`default_nettype none
module rgd_mod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rgd_pkg::RND_W-1:0]  dividend,
  input  wire logic [rgd_pkg::SPAN_W-1:0] divisor,
  output logic                            done,
  output logic [rgd_pkg::SPAN_W-1:0]      remainder
);
  import rgd_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RND_W-1:0]  shreg;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W-1:0] remainder_next;

  always_comb begin
    trial = {remainder, shreg[RND_W-1]};
    if (trial >= {1'b0, dvs}) begin
      remainder_next = SPAN_W'(trial - {1'b0, dvs});
    end else begin
      remainder_next = SPAN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= {shreg[RND_W-2:0], 1'b0};
      remainder <= remainder_next;
    end
  end

endmodule
`default_nettype wire

### rtl/random_gate_distributor_top.sv
// random gate distributor: picks one of the gate outputs on clock edges
//
//  channel  | direction | content
//  s_*      | in        | [0] clock_high [1] mode_button [7:2] min [13:8] max [45:14] random
//  m_*      | out       | [7:0] gates [9:8] current_mode
//  cfg_*    | in        | pulse_ticks
//
// each item passes through accept, the bit-serial remainder unit, handoff
// and update. s_tready is high only while idle.
// the result waits in an output register; a stalled m_tready holds the
// update step. rst is synchronous and needs no clearing pass.
`default_nettype none
module random_gate_distributor_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // clock_high, mode_button, min_request, max_request, random_word, zero pad
  input  wire logic [rgd_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // gates, current_mode, zero pad
  output logic [rgd_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rgd_pkg::PULSE_BITS-1:0] cfg_data
);
  import rgd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MOD    = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]            state;
  logic [PULSE_BITS-1:0] pulse_ticks;
  logic                  clock_seen_high;
  logic                  button_seen_high;
  logic [MODE_W-1:0]     output_mode;
  logic [NUM_GATES-1:0]  active_marks;
  logic [NUM_GATES-1:0]  pulse_edge_seen;
  logic [PULSE_BITS-1:0] pulse_left [NUM_GATES];

  logic                  clk_in;
  logic                  btn_in;
  logic [GATE_BITS-1:0]  lo;

  logic                  accept;
  logic [GATE_BITS-1:0]  lo_req;
  logic [GATE_BITS-1:0]  hi_req;
  logic [GATE_BITS-1:0]  lo_fix;
  logic [SPAN_W-1:0]     span;
  logic                  mod_done;
  logic [SPAN_W-1:0]     rem;

  logic [MODE_W-1:0]     mode_next;
  logic [SPAN_W-1:0]     pick;
  logic                  clk_rise;
  logic [NUM_GATES-1:0]  active_marks_next;
  logic [NUM_GATES-1:0]  pulse_edge_seen_next;
  logic [PULSE_BITS-1:0] pulse_left_next [NUM_GATES];
  logic [NUM_GATES-1:0]  gates_next;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign lo_req = clamp_gate(s_tdata[2 +: REQ_W]);
  assign hi_req = clamp_gate(s_tdata[2 + REQ_W +: REQ_W]);
  assign lo_fix = (lo_req > hi_req) ? hi_req : lo_req;
  assign span   = SPAN_W'(hi_req) - SPAN_W'(lo_fix) + 1'b1;

  rgd_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (s_tdata[2 + 2 * REQ_W +: RND_W]),
    .divisor   (span),
    .done      (mod_done),
    .remainder (rem)
  );

  always_comb begin
    logic              was;
    logic [PULSE_BITS-1:0] left;
    logic              mark;

    if (btn_in && !button_seen_high) begin
      mode_next = (output_mode == MODE_GATE) ? MODE_TRIGGER : output_mode + 1'b1;
    end else begin
      mode_next = output_mode;
    end
    clk_rise = clk_in && !clock_seen_high;
    pick     = rem + SPAN_W'(lo);

    for (int i = 0; i < NUM_GATES; i++) begin
      mark = clk_rise ? (pick == SPAN_W'(i)) : active_marks[i];
      active_marks_next[i]    = mark;
      pulse_edge_seen_next[i] = pulse_edge_seen[i];
      pulse_left_next[i]      = pulse_left[i];
      gates_next[i]           = 1'b0;
      was  = pulse_edge_seen[i];
      left = pulse_left[i];
      unique case (mode_next)
        MODE_TRIGGER: begin
          pulse_edge_seen_next[i] = mark;
          if (mark && !was) begin
            left                 = pulse_ticks;
            active_marks_next[i] = 1'b0;
          end
          if (left != '0) begin
            gates_next[i] = 1'b1;
            left          = left - 1'b1;
          end
          pulse_left_next[i] = left;
        end
        MODE_HOLD: gates_next[i] = mark;
        MODE_GATE: gates_next[i] = mark && clk_in;
        default:   gates_next[i] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pulse_ticks      <= PULSE_RESET;
      clock_seen_high  <= 1'b0;
      button_seen_high <= 1'b0;
      output_mode      <= MODE_TRIGGER;
      active_marks     <= '0;
      pulse_edge_seen  <= '0;
      m_tvalid         <= 1'b0;
      for (int i = 0; i < NUM_GATES; i++) begin
        pulse_left[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        pulse_ticks <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            state            <= ST_IDLE;
            m_tvalid         <= 1'b1;
            button_seen_high <= btn_in;
            clock_seen_high  <= clk_in;
            output_mode      <= mode_next;
            active_marks     <= active_marks_next;
            pulse_edge_seen  <= pulse_edge_seen_next;
            for (int i = 0; i < NUM_GATES; i++) begin
              pulse_left[i] <= pulse_left_next[i];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clk_in <= s_tdata[0];
      btn_in <= s_tdata[1];
      lo     <= lo_fix;
    end
    if (state == ST_UPDATE && out_free) begin
      m_tdata <= OUT_DATA_W'({mode_next, gates_next});
    end
  end

endmodule
`default_nettype wire
